// File: design/epm_pkg.sv
// Shared types and constants for the exact pattern matcher.
// No dependencies; every other design file imports this package.
package epm_pkg;

  localparam int PAT_MAX  = 64;                  // longest pattern held, in bytes
  localparam int POS_BITS = 32;                  // width of the text position counter
  localparam int DATA_W   = 8;                   // one pattern or text byte
  localparam int OUT_W    = 32;                  // width of the start index field
  localparam int CNT_W    = 32;                  // occurrence counter width
  localparam int LEN_W    = $clog2(PAT_MAX + 1); // pattern length, 0..PAT_MAX
  localparam int IDX_W    = $clog2(PAT_MAX);     // cell index, 0..PAT_MAX-1

  typedef enum logic {
    KIND_PATTERN = 1'b0,
    KIND_TEXT    = 1'b1
  } kind_t;

  // Control broadcast to every cell of the comparator row.
  typedef struct packed {
    logic              load;      // write data into the selected cell
    logic [IDX_W-1:0]  load_idx;  // cell that takes the pattern byte
    logic              shift;     // advance the row by one text byte
    logic              clear;     // drop all partial matches
    logic [DATA_W-1:0] data;      // byte under work
  } chain_ctl_t;

endpackage

// File: design/epm_intf.sv
// Valid/ready channel interfaces for the matcher input and result items.
// Depends on epm_pkg for field widths and the kind type.
interface epm_in_if;
  import epm_pkg::*;
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [DATA_W-1:0] byte_value;
  logic              last;

  modport source (output valid, output kind, output byte_value, output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input last, output ready);
endinterface

interface epm_out_if;
  import epm_pkg::*;
  logic             valid;
  logic             ready;
  logic             match;
  logic [OUT_W-1:0] match_start;
  logic [CNT_W-1:0] match_count;
  logic             done_res;
  logic             pattern_error;

  modport source (output valid, output match, output match_start, output match_count,
                  output done_res, output pattern_error, input ready);
  modport sink   (input valid, input match, input match_start, input match_count,
                  input done_res, input pattern_error, output ready);
endinterface

// File: design/epm_cell.sv
// One comparator cell: holds one pattern byte and one partial-match bit.
// Depends on epm_pkg for the control struct.
module epm_cell
  import epm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  input  logic       wr_en,
  input  logic       prev_hit,
  output logic       step_hit,
  output logic       hit_r
);

  logic [DATA_W-1:0] pat_r;

  // Prefix through this cell matches if the left neighbor matched and this byte agrees.
  assign step_hit = prev_hit && (ctl.data == pat_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_r <= ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.clear) begin
      hit_r <= 1'b0;
    end else if (ctl.shift) begin
      hit_r <= step_hit;
    end
  end

endmodule

// File: design/epm_chain.sv
// Row of PAT_MAX comparator cells, each passing its match bit to the right.
// Depends on epm_pkg and epm_cell.
module epm_chain
  import epm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  chain_ctl_t       ctl,
  input  logic [IDX_W-1:0] sel_idx,
  output logic             tap_hit
);

  logic [PAT_MAX-1:0] step_hit;
  logic [PAT_MAX-1:0] hit_r;
  logic [PAT_MAX-1:0] prev_hit;
  logic [PAT_MAX-1:0] wr_en;

  for (genvar j = 0; j < PAT_MAX; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign prev_hit[j] = 1'b1;
    end else begin : g_body
      assign prev_hit[j] = hit_r[j-1];
    end

    assign wr_en[j] = ctl.load && (ctl.load_idx == IDX_W'(j));

    epm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_en    (wr_en[j]),
      .prev_hit (prev_hit[j]),
      .step_hit (step_hit[j]),
      .hit_r    (hit_r[j])
    );
  end

  // Full pattern match shows at the cell of the last pattern byte.
  assign tap_hit = step_hit[sel_idx];

endmodule

// File: design/exact_pattern_matcher_top.sv
// Exact pattern matcher: one byte item per cycle unless the output stalls;
// a result item is registered and valid in the cycle after the text byte that
// causes it. Throughput is one item per cycle, set by the comparator row, which
// updates every cell together. Reset (rst_n, synchronous, active low) empties the
// pattern, zeroes the position, count and partial matches and opens a pattern
// load; stored pattern bytes are undefined until loaded.
module exact_pattern_matcher_top
  import epm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  epm_in_if.sink    in_ch,
  epm_out_if.source out_ch
);

  // Control state
  logic                loading_r, loading_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // Result register
  logic             out_valid_r;
  logic             out_match_r;
  logic [OUT_W-1:0] out_start_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_done_r;
  logic             out_error_r;

  logic                fire;
  logic                is_text;
  logic [LEN_W-1:0]    base_len;
  logic                room;
  logic                tap_hit;
  logic                hit;
  logic [IDX_W-1:0]    sel_idx;
  logic [POS_BITS-1:0] span;
  logic [POS_BITS-1:0] start;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    cnt_res;
  logic                emit;
  chain_ctl_t          ctl;

  // Take a new item whenever the result register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign is_text     = (in_ch.kind == KIND_TEXT);

  // A pattern byte outside an open load starts a fresh pattern at index zero.
  assign base_len = loading_r ? len_r : '0;
  assign room     = (base_len < LEN_W'(PAT_MAX));

  // Broadcast to the cell row. Any pattern item or the last text byte clears the
  // partial matches; while a load is open they are already clear.
  always_comb begin
    ctl.load     = fire && !is_text && room;
    ctl.load_idx = IDX_W'(base_len);
    ctl.shift    = fire && is_text;
    ctl.clear    = fire && (!is_text || in_ch.last);
    ctl.data     = in_ch.byte_value;
  end

  // Watch the cell holding the last pattern byte; shorter than two never matches.
  assign sel_idx = IDX_W'(len_r - LEN_W'(1));
  assign hit     = (len_r >= LEN_W'(2)) && tap_hit;

  epm_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sel_idx (sel_idx),
    .tap_hit (tap_hit)
  );

  // Start index of an occurrence ending at the current position.
  assign span  = POS_BITS'(len_r) - POS_BITS'(1);
  assign start = (pos_r >= span) ? (pos_r - span) : '0;

  // Saturating occurrence count including this byte's hit.
  assign cnt_inc = (cnt_r != '1) ? (cnt_r + CNT_W'(1)) : cnt_r;
  assign cnt_res = hit ? cnt_inc : cnt_r;

  assign emit = fire && is_text && (hit || in_ch.last);

  always_comb begin
    loading_nxt = loading_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    if (fire) begin
      if (!is_text) begin
        // Pattern byte: extend the load, drop extra bytes, close on last, zero position and count.
        loading_nxt = !in_ch.last;
        len_nxt     = room ? (base_len + LEN_W'(1)) : base_len;
        pos_nxt     = '0;
        cnt_nxt     = '0;
      end else begin
        // Text byte: close any open load, advance position, reset after last.
        loading_nxt = 1'b0;
        if (in_ch.last) begin
          pos_nxt = '0;
          cnt_nxt = '0;
        end else begin
          pos_nxt = (pos_r != '1) ? (pos_r + POS_BITS'(1)) : pos_r;
          cnt_nxt = cnt_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r <= 1'b1;
      len_r     <= '0;
      pos_r     <= '0;
      cnt_r     <= '0;
    end else begin
      loading_r <= loading_nxt;
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Hold the result until taken; refill in the same cycle it drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_match_r <= hit;
      out_start_r <= hit ? OUT_W'(start) : '0;
      out_count_r <= cnt_res;
      out_done_r  <= in_ch.last;
      out_error_r <= in_ch.last && (len_r < LEN_W'(2));
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.match         = out_match_r;
  assign out_ch.match_start   = out_start_r;
  assign out_ch.match_count   = out_count_r;
  assign out_ch.done_res      = out_done_r;
  assign out_ch.pattern_error = out_error_r;

`ifndef SYNTHESIS
  // A pattern byte never creates a result item.
  a_pattern_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_text) |=> (out_valid_r == $past(out_valid_r && !out_ch.ready)))
    else $error("result item created by a pattern byte");

  // A reported match needs a pattern of at least two bytes.
  a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_match_r) |-> (len_r >= LEN_W'(2)))
    else $error("match reported with a short pattern");

  // A reported match is counted.
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_match_r) |-> (out_count_r != '0))
    else $error("match reported with zero count");

  // The last text byte returns position and count to zero.
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_text && in_ch.last) |=> (pos_r == '0 && cnt_r == '0))
    else $error("text state not cleared after last byte");
`endif

endmodule
